// ===== rtl/rvm_pkg.sv =====
// shared operation codes and pipeline payload type for the rv32m multiply/divide unit
`default_nettype none
package rvm_pkg;

	localparam logic [2:0] OP_MUL    = 3'b000;
	localparam logic [2:0] OP_MULH   = 3'b001;
	localparam logic [2:0] OP_MULHSU = 3'b010;
	localparam logic [2:0] OP_MULHU  = 3'b011;
	localparam logic [2:0] OP_DIV    = 3'b100;
	localparam logic [2:0] OP_DIVU   = 3'b101;
	localparam logic [2:0] OP_REM    = 3'b110;
	localparam logic [2:0] OP_REMU   = 3'b111;

	localparam int unsigned XLEN = 32;

	// payload that moves down the pipeline
	// multiplies: hi/lo hold operands, then the 64-bit product magnitude
	// divides: hi is the partial remainder, lo the dividend/quotient, dvs the divisor
	typedef struct packed {
		logic [2:0]      op;
		logic            neg;
		logic [XLEN-1:0] hi;
		logic [XLEN-1:0] lo;
		logic [XLEN-1:0] dvs;
	} pl_t;

endpackage
`default_nettype wire

// ===== rtl/rvm_prep.sv =====
// operand decode: magnitudes, result sign and initial divider state
`default_nettype none
module rvm_prep (
	input  wire logic [2:0]  action,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	output rvm_pkg::pl_t     prep
);
	import rvm_pkg::*;

	logic        a_sgn;
	logic        b_sgn;
	logic [31:0] a_mag;
	logic [31:0] b_mag;
	logic        b_zero;

	always_comb begin
		a_sgn  = 1'b0;
		b_sgn  = 1'b0;
		b_zero = (operand_b == 32'd0);
		case (action)
			OP_MULH, OP_DIV, OP_REM: begin
				a_sgn = operand_a[31];
				b_sgn = operand_b[31];
			end
			OP_MULHSU: begin
				a_sgn = operand_a[31];
			end
			default: begin
			end
		endcase
		a_mag = a_sgn ? (32'd0 - operand_a) : operand_a;
		b_mag = b_sgn ? (32'd0 - operand_b) : operand_b;

		prep.op  = action;
		prep.dvs = b_mag;
		if (action[2] == 1'b0) begin
			prep.neg = a_sgn ^ b_sgn;
			prep.hi  = a_mag;
			prep.lo  = b_mag;
		end else begin
			prep.hi = 32'd0;
			prep.lo = a_mag;
			// zero divisor: quotient stays all ones, remainder keeps dividend sign
			if (action == OP_DIV) begin
				prep.neg = (a_sgn ^ b_sgn) & ~b_zero;
			end else begin
				prep.neg = a_sgn;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rvm_mul.sv =====
// pipeline stage with the 32x32 unsigned magnitude multiplier
`default_nettype none
module rvm_mul (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    up_valid,
	output logic         up_ready,
	input  wire rvm_pkg::pl_t up_data,
	output logic         dn_valid,
	input  wire logic    dn_ready,
	output rvm_pkg::pl_t dn_data
);
	import rvm_pkg::*;

	logic        valid_s2;
	pl_t         data_s2;
	logic [63:0] prod;
	pl_t         nxt;

	assign prod     = 64'(up_data.hi) * 64'(up_data.lo);
	assign up_ready = ~valid_s2 | dn_ready;
	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

	// divide transactions ride through untouched
	always_comb begin
		nxt = up_data;
		if (up_data.op[2] == 1'b0) begin
			nxt.hi = prod[63:32];
			nxt.lo = prod[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rvm_div_step.sv =====
// one restoring division step with its pipeline register
`default_nettype none
module rvm_div_step (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    up_valid,
	output logic         up_ready,
	input  wire rvm_pkg::pl_t up_data,
	output logic         dn_valid,
	input  wire logic    dn_ready,
	output rvm_pkg::pl_t dn_data
);
	import rvm_pkg::*;

	logic        valid_q;
	pl_t         data_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        fits;
	pl_t         nxt;

	always_comb begin
		trial = {up_data.hi, up_data.lo[31]};
		diff  = trial - {1'b0, up_data.dvs};
		fits  = ~diff[32];
		nxt   = up_data;
		// multiply results ride through untouched
		if (up_data.op[2]) begin
			nxt.hi = fits ? diff[31:0] : trial[31:0];
			nxt.lo = {up_data.lo[30:0], fits};
		end
	end

	assign up_ready = ~valid_q | dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rvm_fixup.sv =====
// result selection and sign correction
`default_nettype none
module rvm_fixup (
	input  wire rvm_pkg::pl_t fin,
	output logic [31:0]       res
);
	import rvm_pkg::*;

	logic [63:0] prod;
	logic [63:0] prod_fix;
	logic [31:0] quo_fix;
	logic [31:0] rem_fix;

	always_comb begin
		prod     = {fin.hi, fin.lo};
		prod_fix = fin.neg ? (64'd0 - prod) : prod;
		quo_fix  = fin.neg ? (32'd0 - fin.lo) : fin.lo;
		rem_fix  = fin.neg ? (32'd0 - fin.hi) : fin.hi;
		case (fin.op)
			OP_MUL:                       res = prod_fix[31:0];
			OP_MULH, OP_MULHSU, OP_MULHU: res = prod_fix[63:32];
			OP_DIV, OP_DIVU:              res = quo_fix;
			default:                      res = rem_fix;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/rv32m_multiply_divide_unit.sv =====
// top level of the pipelined rv32m multiply/divide unit
`default_nettype none
// RV32M multiply/divide unit: MUL, MULH, MULHSU, MULHU, DIV, DIVU, REM and REMU on
// two 32-bit operands, one 32-bit result per transaction. Fully pipelined: a new
// transaction can be accepted every cycle unless a low out_ready has backed the
// pipeline up to the input, and each passes 35 register stages (one decode stage,
// one multiplier stage, 32 division steps of one quotient bit each, one result stage). The latency is set by the
// 32-step restoring divider chain, which every transaction passes through so that
// results leave in order. Every stage has its own valid bit and a stage may fill
// whenever it is empty or its content moves on, so bubbles close up even while
// the output transaction waits. Divide by zero gives all ones (DIV/DIVU) or the
// dividend (REM/REMU); -2^31 / -1 gives -2^31 with remainder 0.
module rv32m_multiply_divide_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  action,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result
);
	import rvm_pkg::*;

	localparam int unsigned STEPS = XLEN;

	// decode stage
	pl_t  prep;
	logic valid_s1;
	pl_t  data_s1;
	logic ready_s1;

	// multiplier stage outputs
	logic mul_valid;
	logic mul_ready;
	pl_t  mul_data;

	// divider chain: element k is the output of step k
	logic       step_valid [STEPS];
	logic       step_ready [STEPS];
	pl_t        step_data  [STEPS];

	// result stage
	logic        valid_q;
	logic [31:0] result_q;
	logic        res_ready;
	logic [31:0] res_next;

	rvm_prep u_prep (
		.action    (action),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.prep      (prep)
	);

	assign in_ready = ~valid_s1 | ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= prep;
		end
	end

	// magnitude product for the multiply group
	rvm_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s1),
		.up_ready (ready_s1),
		.up_data  (data_s1),
		.dn_valid (mul_valid),
		.dn_ready (mul_ready),
		.dn_data  (mul_data)
	);

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		if (k == 0) begin : g_first
			rvm_div_step u_step (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid (mul_valid),
				.up_ready (mul_ready),
				.up_data  (mul_data),
				.dn_valid (step_valid[k]),
				.dn_ready (step_ready[k]),
				.dn_data  (step_data[k])
			);
		end else begin : g_next
			rvm_div_step u_step (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid (step_valid[k-1]),
				.up_ready (step_ready[k-1]),
				.up_data  (step_data[k-1]),
				.dn_valid (step_valid[k]),
				.dn_ready (step_ready[k]),
				.dn_data  (step_data[k])
			);
		end
	end

	// sign fix and selection into the output register
	rvm_fixup u_fixup (
		.fin (step_data[STEPS-1]),
		.res (res_next)
	);

	assign res_ready              = ~valid_q | out_ready;
	assign step_ready[STEPS-1]    = res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= step_valid[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && step_valid[STEPS-1]) begin
			result_q <= res_next;
		end
	end

	assign out_valid = valid_q;
	assign result    = result_q;

endmodule
`default_nettype wire
